[rtl/core/mbet_pkg.sv]
// Shared types and constants for the multibrot escape-time block.
package mbet_pkg;

   localparam int IO_COORD_WIDTH  = 32;
   localparam int NORM_WIDTH      = 32;
   localparam int COUNT_WIDTH     = 16;
   localparam int POWER_WIDTH     = 5;
   localparam int RADIUS_WIDTH    = 15;
   localparam int BAIL_WIDTH      = 2 * RADIUS_WIDTH;
   localparam int STEP_CNT_WIDTH  = 4;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POWER      = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RADIUS     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_ITER   = 2'd2;

   localparam logic [POWER_WIDTH-1:0]  POWER_RESET    = 5'd2;
   localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET   = 15'd512;
   localparam logic [COUNT_WIDTH-1:0]  MAX_ITER_RESET = 16'd256;
   localparam logic [POWER_WIDTH-1:0]  POWER_MIN      = 5'd2;
   localparam logic [POWER_WIDTH-1:0]  POWER_MAX      = 5'd16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ITER,
      ST_MUL,
      ST_WAIT,
      ST_ACT,
      ST_ADDC,
      ST_TEST,
      ST_FINISH
   } state_type;

   // Which product is formed, and what is done with it.
   typedef enum logic [2:0] {
      STEP_RR,   // pr * zr, held
      STEP_II,   // pi * zi, subtracted -> new real
      STEP_RI,   // pr * zi, held
      STEP_IR,   // pi * zr, added -> new imag
      STEP_SQR,  // zr squared
      STEP_SQI   // zi squared -> norm
   } step_type;

   typedef struct packed {
      logic                   load;
      logic                   iter_begin;
      logic                   add_c;
      logic                   mul_start;
      logic                   act_en;
      step_type               step;
      logic                   res_load;
      logic [COUNT_WIDTH-1:0] res_count;
      logic                   res_inside;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic escaped;
   } status_type;

endpackage

[rtl/core/mbet_if.sv]
// Request and response channel interfaces.
interface mbet_req_if
   import mbet_pkg::*;
   ();
   logic                             valid;
   logic                             ready;
   logic signed [IO_COORD_WIDTH-1:0] c_real;
   logic signed [IO_COORD_WIDTH-1:0] c_imag;

   modport source (output valid, output c_real, output c_imag, input ready);
   modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

interface mbet_rsp_if
   import mbet_pkg::*;
   ();
   logic                             valid;
   logic                             ready;
   logic [COUNT_WIDTH-1:0]           iteration_count;
   logic                             inside_set;
   logic signed [IO_COORD_WIDTH-1:0] escape_real;
   logic signed [IO_COORD_WIDTH-1:0] escape_imag;
   logic [NORM_WIDTH-1:0]            escape_norm;

   modport source (output valid, output iteration_count, output inside_set,
                   output escape_real, output escape_imag, output escape_norm,
                   input ready);
   modport sink   (input valid, input iteration_count, input inside_set,
                   input escape_real, input escape_imag, input escape_norm,
                   output ready);
endinterface

[rtl/core/mbet_mul.sv]
// Iterative unsigned multiplier: four half-width partial products, one per cycle.
module mbet_mul
   import mbet_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [WIDTH-1:0]               a,
   input  logic [WIDTH-1:0]               b,
   output logic [4*((WIDTH+1)/2)-1:0]     product,
   output logic                           done
);

   localparam int H  = (WIDTH + 1) / 2;
   localparam int OW = 2 * H;
   localparam int PW = 4 * H;

   logic [OW-1:0] a_ff, a_in, b_ff, b_in;
   logic [1:0]    phase_ff, phase_in, add_phase_ff, add_phase_in;
   logic          busy_ff, busy_in, add_valid_ff, add_valid_in, done_ff, done_in;
   logic [OW-1:0] pp_ff, pp_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic [H-1:0]  a_part, b_part;
   logic [PW-1:0] sh0, sh1, sh2;

   always_comb begin
      // phase bit 1 picks the high half of a, bit 0 the high half of b
      a_part = phase_ff[1] ? a_ff[OW-1:H] : a_ff[H-1:0];
      b_part = phase_ff[0] ? b_ff[OW-1:H] : b_ff[H-1:0];
      sh0    = PW'(pp_ff);
      sh1    = add_phase_ff[0] ? (sh0 << H) : sh0;
      sh2    = add_phase_ff[1] ? (sh1 << H) : sh1;
   end

   always_comb begin
      a_in         = a_ff;
      b_in         = b_ff;
      phase_in     = phase_ff;
      busy_in      = busy_ff;
      pp_in        = pp_ff;
      add_valid_in = 1'b0;
      add_phase_in = add_phase_ff;
      acc_in       = acc_ff;
      done_in      = add_valid_ff && (add_phase_ff == 2'd3);
      if (busy_ff) begin
         pp_in        = OW'(a_part) * OW'(b_part);
         add_valid_in = 1'b1;
         add_phase_in = phase_ff;
         phase_in     = phase_ff + 2'd1;
         if (phase_ff == 2'd3) begin
            busy_in = 1'b0;
         end
      end
      if (add_valid_ff) begin
         acc_in = acc_ff + sh2;
      end
      if (start) begin
         a_in     = OW'(a);
         b_in     = OW'(b);
         phase_in = 2'd0;
         busy_in  = 1'b1;
         acc_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         add_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         add_valid_ff <= add_valid_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      b_ff         <= b_in;
      phase_ff     <= phase_in;
      pp_ff        <= pp_in;
      add_phase_ff <= add_phase_in;
      acc_ff       <= acc_in;
   end

   assign product = acc_ff;
   assign done    = done_ff;

endmodule

[rtl/core/mbet_datapath.sv]
// Coordinate registers, product rounding and saturation, norm and result register.
module mbet_datapath
   import mbet_pkg::*;
#(
   parameter int FRAC_BITS   = 24,
   parameter int COORD_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cmd_type                          cmd,
   output status_type                       status,
   input  logic signed [IO_COORD_WIDTH-1:0] req_c_real,
   input  logic signed [IO_COORD_WIDTH-1:0] req_c_imag,
   input  logic [RADIUS_WIDTH-1:0]          radius,
   output logic [COUNT_WIDTH-1:0]           rsp_count,
   output logic                             rsp_inside,
   output logic signed [IO_COORD_WIDTH-1:0] rsp_real,
   output logic signed [IO_COORD_WIDTH-1:0] rsp_imag,
   output logic [NORM_WIDTH-1:0]            rsp_norm
);

   localparam int CW       = COORD_WIDTH;
   localparam int PW       = 4 * ((CW + 1) / 2);
   localparam int EW       = (CW > IO_COORD_WIDTH) ? CW : IO_COORD_WIDTH;
   localparam int SQ_SHIFT = 2 * FRAC_BITS - 16;

   localparam logic [PW-1:0] LIM_POS = {{(PW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic [PW-1:0] LIM_NEG = {{(PW-CW){1'b0}}, 1'b1, {(CW-1){1'b0}}};
   localparam logic [PW-1:0] ONES_N  = {{(PW-NORM_WIDTH){1'b0}}, {NORM_WIDTH{1'b1}}};
   localparam logic signed [EW-1:0] CMAX_W = EW'($signed({1'b0, {(CW-1){1'b1}}}));
   localparam logic signed [EW-1:0] CMIN_W = ~CMAX_W;
   localparam logic signed [EW-1:0] OMAX_W =
      EW'($signed({1'b0, {(IO_COORD_WIDTH-1){1'b1}}}));
   localparam logic signed [EW-1:0] OMIN_W = ~OMAX_W;

   logic [CW-1:0]           c_r_ff, c_r_in, c_i_ff, c_i_in;
   logic [CW-1:0]           z_r_ff, z_r_in, z_i_ff, z_i_in;
   logic [CW-1:0]           p_r_ff, p_r_in, p_i_ff, p_i_in;
   logic [CW-1:0]           t_ff, t_in, nr_ff, nr_in, fx_ff, fx_in;
   logic [NORM_WIDTH-1:0]   sqv_ff, sqv_in, sq_ff, sq_in, norm_ff, norm_in;
   logic [BAIL_WIDTH-1:0]   bail_ff, bail_in;
   logic                    neg_ff, neg_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic                    inside_ff, inside_in;
   logic [IO_COORD_WIDTH-1:0] out_r_ff, out_r_in, out_i_ff, out_i_in;
   logic [NORM_WIDTH-1:0]   out_n_ff, out_n_in;

   logic [CW-1:0]           op_a, op_b, mag_a, mag_b;
   logic [PW-1:0]           prod, prod_fx, prod_sq, m_clip;
   logic                    mul_done;
   logic [NORM_WIDTH:0]     norm_sum;

   function automatic logic [CW-1:0] sat_sum(input logic [CW:0] s);
      logic [CW-1:0] r;
      if (s[CW] != s[CW-1]) begin
         r = s[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
         r = s[CW-1:0];
      end
      return r;
   endfunction

   function automatic logic [CW-1:0] in_sat(input logic signed [IO_COORD_WIDTH-1:0] v);
      logic signed [EW-1:0] w;
      logic [CW-1:0]        r;
      w = EW'(v);
      if (w > CMAX_W) begin
         r = CMAX_W[CW-1:0];
      end else if (w < CMIN_W) begin
         r = CMIN_W[CW-1:0];
      end else begin
         r = w[CW-1:0];
      end
      return r;
   endfunction

   function automatic logic [IO_COORD_WIDTH-1:0] out_sat(input logic [CW-1:0] v);
      logic signed [EW-1:0]      w;
      logic [IO_COORD_WIDTH-1:0] r;
      w = EW'($signed(v));
      if (w > OMAX_W) begin
         r = OMAX_W[IO_COORD_WIDTH-1:0];
      end else if (w < OMIN_W) begin
         r = OMIN_W[IO_COORD_WIDTH-1:0];
      end else begin
         r = w[IO_COORD_WIDTH-1:0];
      end
      return r;
   endfunction

   // operand selection for the shared multiplier
   always_comb begin
      case (cmd.step)
         STEP_RR: begin
            op_a = p_r_ff;
            op_b = z_r_ff;
         end
         STEP_II: begin
            op_a = p_i_ff;
            op_b = z_i_ff;
         end
         STEP_RI: begin
            op_a = p_r_ff;
            op_b = z_i_ff;
         end
         STEP_IR: begin
            op_a = p_i_ff;
            op_b = z_r_ff;
         end
         STEP_SQR: begin
            op_a = z_r_ff;
            op_b = z_r_ff;
         end
         STEP_SQI: begin
            op_a = z_i_ff;
            op_b = z_i_ff;
         end
         default: begin
            op_a = z_r_ff;
            op_b = z_r_ff;
         end
      endcase
      mag_a = op_a[CW-1] ? (~op_a + 1'b1) : op_a;
      mag_b = op_b[CW-1] ? (~op_b + 1'b1) : op_b;
   end

   mbet_mul #(
      .WIDTH (CW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .a       (mag_a),
      .b       (mag_b),
      .product (prod),
      .done    (mul_done)
   );

   // rounding toward zero of the magnitude, then clip to the coordinate range
   always_comb begin
      prod_fx = prod >> FRAC_BITS;
      prod_sq = prod >> SQ_SHIFT;
      if (neg_ff) begin
         m_clip = (prod_fx > LIM_NEG) ? LIM_NEG : prod_fx;
      end else begin
         m_clip = (prod_fx > LIM_POS) ? LIM_POS : prod_fx;
      end
      norm_sum = {1'b0, sq_ff} + {1'b0, sqv_ff};
   end

   always_comb begin
      c_r_in    = c_r_ff;
      c_i_in    = c_i_ff;
      z_r_in    = z_r_ff;
      z_i_in    = z_i_ff;
      p_r_in    = p_r_ff;
      p_i_in    = p_i_ff;
      t_in      = t_ff;
      nr_in     = nr_ff;
      fx_in     = fx_ff;
      sqv_in    = sqv_ff;
      sq_in     = sq_ff;
      norm_in   = norm_ff;
      bail_in   = bail_ff;
      neg_in    = neg_ff;
      count_in  = count_ff;
      inside_in = inside_ff;
      out_r_in  = out_r_ff;
      out_i_in  = out_i_ff;
      out_n_in  = out_n_ff;

      if (cmd.load) begin
         c_r_in  = in_sat(req_c_real);
         c_i_in  = in_sat(req_c_imag);
         z_r_in  = '0;
         z_i_in  = '0;
         norm_in = '0;
         bail_in = BAIL_WIDTH'(radius) * BAIL_WIDTH'(radius);
      end
      if (cmd.iter_begin) begin
         p_r_in = z_r_ff;
         p_i_in = z_i_ff;
      end
      if (cmd.add_c) begin
         z_r_in = sat_sum({p_r_ff[CW-1], p_r_ff} + {c_r_ff[CW-1], c_r_ff});
         z_i_in = sat_sum({p_i_ff[CW-1], p_i_ff} + {c_i_ff[CW-1], c_i_ff});
      end
      if (cmd.mul_start) begin
         neg_in = op_a[CW-1] ^ op_b[CW-1];
      end
      if (mul_done) begin
         fx_in  = neg_ff ? (~m_clip[CW-1:0] + 1'b1) : m_clip[CW-1:0];
         sqv_in = (prod_sq > ONES_N) ? {NORM_WIDTH{1'b1}} : prod_sq[NORM_WIDTH-1:0];
      end
      if (cmd.act_en) begin
         case (cmd.step)
            STEP_RR: t_in = fx_ff;
            STEP_II: nr_in = sat_sum({t_ff[CW-1], t_ff} - {fx_ff[CW-1], fx_ff});
            STEP_RI: t_in = fx_ff;
            STEP_IR: begin
               p_r_in = nr_ff;
               p_i_in = sat_sum({t_ff[CW-1], t_ff} + {fx_ff[CW-1], fx_ff});
            end
            STEP_SQR: sq_in = sqv_ff;
            STEP_SQI: begin
               norm_in = norm_sum[NORM_WIDTH] ? {NORM_WIDTH{1'b1}}
                                              : norm_sum[NORM_WIDTH-1:0];
            end
            default: t_in = t_ff;
         endcase
      end
      if (cmd.res_load) begin
         count_in  = cmd.res_count;
         inside_in = cmd.res_inside;
         out_r_in  = out_sat(z_r_ff);
         out_i_in  = out_sat(z_i_ff);
         out_n_in  = norm_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_r_ff    <= c_r_in;
      c_i_ff    <= c_i_in;
      z_r_ff    <= z_r_in;
      z_i_ff    <= z_i_in;
      p_r_ff    <= p_r_in;
      p_i_ff    <= p_i_in;
      t_ff      <= t_in;
      nr_ff     <= nr_in;
      fx_ff     <= fx_in;
      sqv_ff    <= sqv_in;
      sq_ff     <= sq_in;
      norm_ff   <= norm_in;
      bail_ff   <= bail_in;
      neg_ff    <= neg_in;
      count_ff  <= count_in;
      inside_ff <= inside_in;
      out_r_ff  <= out_r_in;
      out_i_ff  <= out_i_in;
      out_n_ff  <= out_n_in;
   end

   assign status.mul_done = mul_done;
   assign status.escaped  = norm_ff > {{(NORM_WIDTH-BAIL_WIDTH){1'b0}}, bail_ff};

   assign rsp_count  = count_ff;
   assign rsp_inside = inside_ff;
   assign rsp_real   = out_r_ff;
   assign rsp_imag   = out_i_ff;
   assign rsp_norm   = out_n_ff;

endmodule

[rtl/core/mbet_ctrl.sv]
// Sequencer: iteration, power and product-step counters, handshakes.
module mbet_ctrl
   import mbet_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [POWER_WIDTH-1:0] power,
   input  logic [COUNT_WIDTH-1:0] max_iter,
   input  status_type             status,
   output cmd_type                cmd
);

   state_type                 state_ff, state_in;
   step_type                  step_ff, step_in;
   logic [STEP_CNT_WIDTH-1:0] k_ff, k_in;
   logic [POWER_WIDTH-1:0]    n_ff, n_in;
   logic [COUNT_WIDTH-1:0]    i_ff, i_in;
   logic [COUNT_WIDTH-1:0]    res_count_ff, res_count_in;
   logic                      res_inside_ff, res_inside_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COUNT_WIDTH:0]      i_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      k_ff          <= k_in;
      n_ff          <= n_in;
      i_ff          <= i_in;
      res_count_ff  <= res_count_in;
      res_inside_ff <= res_inside_in;
   end

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      k_in           = k_ff;
      n_in           = n_ff;
      i_in           = i_ff;
      res_count_in   = res_count_ff;
      res_inside_in  = res_inside_ff;
      i_next         = {1'b0, i_ff} + 1'b1;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.step       = step_ff;
      cmd.res_count  = res_count_ff;
      cmd.res_inside = res_inside_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load      = 1'b1;
               i_in          = '0;
               res_count_in  = max_iter;
               res_inside_in = 1'b1;
               if (power < POWER_MIN) begin
                  n_in = POWER_MIN;
               end else if (power > POWER_MAX) begin
                  n_in = POWER_MAX;
               end else begin
                  n_in = power;
               end
               state_in = (max_iter == '0) ? ST_FINISH : ST_ITER;
            end
         end
         ST_ITER: begin
            cmd.iter_begin = 1'b1;
            k_in           = STEP_CNT_WIDTH'(1);
            step_in        = STEP_RR;
            state_in       = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_start = 1'b1;
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.mul_done) begin
               state_in = ST_ACT;
            end
         end
         ST_ACT: begin
            cmd.act_en = 1'b1;
            state_in   = ST_MUL;
            case (step_ff)
               STEP_RR: step_in = STEP_II;
               STEP_II: step_in = STEP_RI;
               STEP_RI: step_in = STEP_IR;
               STEP_IR: begin
                  // one complex multiply done; z^n needs n-1 of them
                  if ({1'b0, k_ff} == n_ff - 1'b1) begin
                     state_in = ST_ADDC;
                  end else begin
                     k_in    = k_ff + 1'b1;
                     step_in = STEP_RR;
                  end
               end
               STEP_SQR: step_in = STEP_SQI;
               STEP_SQI: state_in = ST_TEST;
               default:  state_in = ST_IDLE;
            endcase
         end
         ST_ADDC: begin
            cmd.add_c = 1'b1;
            step_in   = STEP_SQR;
            state_in  = ST_MUL;
         end
         ST_TEST: begin
            if (status.escaped) begin
               res_count_in  = i_ff;
               res_inside_in = 1'b0;
               state_in      = ST_FINISH;
            end else if (i_next == {1'b0, max_iter}) begin
               state_in = ST_FINISH;
            end else begin
               i_in     = i_next[COUNT_WIDTH-1:0];
               state_in = ST_ITER;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.res_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || cmd.res_load;
   end

   assign rsp_valid = rsp_valid_ff;

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("response raised outside finish");

   a_act_after_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ACT |-> $past(status.mul_done))
      else $error("product used before multiplier finished");

   a_load_clears_count: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> i_ff == '0)
      else $error("iteration counter not cleared on load");

   a_power_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL || state_ff == ST_WAIT || state_ff == ST_ACT)
         |-> ({1'b0, k_ff} < n_ff && n_ff >= POWER_MIN && n_ff <= POWER_MAX))
      else $error("complex multiply count out of range");

endmodule

[rtl/core/multibrot_escape_time.sv]
// Top level of the multibrot escape-time block: CSRs, sequencer and datapath.
//
//   port          dir   beat content
//   req_channel   in    c_real, c_imag (signed Q8.24)
//   rsp_channel   out   iteration_count, inside_set, escape_real/imag, escape_norm
//   csr_*         in    power, escape_radius, max_iterations by index
//
// One point at a time. Every real product goes through one shared multiplier
// (four half-width partial products). One iteration, for power n, runs n-1
// complex multiplies, adds c and forms the norm. A new point is taken while the
// last result waits.
// Reset is synchronous and clears control state only; CSRs return to defaults.
module multibrot_escape_time
   import mbet_pkg::*;
#(
   parameter int FRAC_BITS   = 24,
   parameter int COORD_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   mbet_req_if.sink                   req_channel,
   mbet_rsp_if.source                 rsp_channel,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   logic [POWER_WIDTH-1:0]  power_ff, power_in;
   logic [RADIUS_WIDTH-1:0] radius_ff, radius_in;
   logic [COUNT_WIDTH-1:0]  max_iter_ff, max_iter_in;

   cmd_type    cmd;
   status_type status;

   always_comb begin
      power_in    = power_ff;
      radius_in   = radius_ff;
      max_iter_in = max_iter_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_POWER:    power_in    = csr_write_data[POWER_WIDTH-1:0];
            CSR_RADIUS:   radius_in   = csr_write_data[RADIUS_WIDTH-1:0];
            CSR_MAX_ITER: max_iter_in = csr_write_data[COUNT_WIDTH-1:0];
            default:      power_in    = power_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_ff    <= POWER_RESET;
         radius_ff   <= RADIUS_RESET;
         max_iter_ff <= MAX_ITER_RESET;
      end else begin
         power_ff    <= power_in;
         radius_ff   <= radius_in;
         max_iter_ff <= max_iter_in;
      end
   end

   mbet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_ready (req_channel.ready),
      .rsp_valid (rsp_channel.valid),
      .rsp_ready (rsp_channel.ready),
      .power     (power_ff),
      .max_iter  (max_iter_ff),
      .status    (status),
      .cmd       (cmd)
   );

   mbet_datapath #(
      .FRAC_BITS   (FRAC_BITS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_c_real (req_channel.c_real),
      .req_c_imag (req_channel.c_imag),
      .radius     (radius_ff),
      .rsp_count  (rsp_channel.iteration_count),
      .rsp_inside (rsp_channel.inside_set),
      .rsp_real   (rsp_channel.escape_real),
      .rsp_imag   (rsp_channel.escape_imag),
      .rsp_norm   (rsp_channel.escape_norm)
   );

endmodule
